>>> hdl/raxp_pkg.sv
// Shared types, constants and helper functions of the rotate-add-xor pool generator.
`default_nettype none

package raxp_pkg;

    localparam int WORD_W     = 64;
    localparam int IDX_W      = 5;
    localparam int POOL_WORDS = 20;

    // The advance step works in four groups of five pool words.
    localparam int GROUPS      = 4;
    localparam int GROUP_WORDS = 5;
    localparam int PICKS       = 4;
    localparam int PICK_STRIDE = 3;

    localparam logic [WORD_W-1:0] COUNTER_STEP = 64'd1111111111111;

    // Rotation amounts of the mixing chain.
    localparam int ROT_GROUP = 19;
    localparam int ROT_POOL  = 51;
    localparam int ROT_FOLD1 = 47;
    localparam int ROT_FOLD2 = 25;

    // State word indexes of a write request.
    localparam logic [IDX_W-1:0] WIDX_COUNTER = 5'd20;
    localparam logic [IDX_W-1:0] WIDX_MIX1    = 5'd21;
    localparam logic [IDX_W-1:0] WIDX_MIX2    = 5'd22;

    // Function codes of an input request.
    localparam logic FUNC_ADVANCE = 1'b0;
    localparam logic FUNC_WRITE   = 1'b1;

    typedef enum logic [2:0] {
        OP_ADVANCE,
        OP_WR_POOL,
        OP_WR_COUNTER,
        OP_WR_MIX1,
        OP_WR_MIX2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_GROUP,
        ST_MADD,
        ST_CHAIN,
        ST_FOLD
    } back_state_t;

    typedef struct packed {
        logic              func;
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] word_value;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  out_index;
        logic [WORD_W-1:0] out_value;
        logic              out_last;
    } result_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  widx;
        logic [WORD_W-1:0] value;
    } req_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                                 input int unsigned r);
        return (v << r) | (v >> (WORD_W - r));
    endfunction

endpackage

`default_nettype wire

>>> hdl/raxp_front.sv
// Front end: accepts requests, decodes them and holds them in a two-entry queue.
`default_nettype none

module raxp_front
    import raxp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    output logic       req_valid,
    output req_t       req,
    input  wire logic  req_ready
);

    req_t        q_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        accept;
    logic        keep;
    logic        take;
    req_t        dec;

    // Writes beyond the last state word are accepted and dropped here.
    always_comb
    begin
        dec.widx  = item.word_index;
        dec.value = item.word_value;
        dec.op    = OP_ADVANCE;
        keep      = 1'b1;
        if (item.func == FUNC_WRITE)
        begin
            if (item.word_index < IDX_W'(POOL_WORDS))
                dec.op = OP_WR_POOL;
            else if (item.word_index == WIDX_COUNTER)
                dec.op = OP_WR_COUNTER;
            else if (item.word_index == WIDX_MIX1)
                dec.op = OP_WR_MIX1;
            else if (item.word_index == WIDX_MIX2)
                dec.op = OP_WR_MIX2;
            else
                keep = 1'b0;
        end
    end

    assign full      = (cnt_reg == 2'd2);
    assign accept    = push && !full;
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rd_ptr_reg];
    assign take      = req_valid && req_ready;

    always_ff @(posedge clk)
    begin
        if (accept && keep)
            q_reg[wr_ptr_reg] <= dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (accept && keep)
                wr_ptr_reg <= !wr_ptr_reg;
            if (take)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'((accept && keep) ? 1 : 0) - 2'(take ? 1 : 0);
        end
    end

endmodule

`default_nettype wire

>>> hdl/raxp_back.sv
// Back end: state words, pool memory and the sequencer of the advance step.
`default_nettype none

module raxp_back
    import raxp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    input  wire req_t  req,
    output logic       req_ready,
    output logic       out_push,
    output result_t    out_data,
    input  wire logic  out_full
);

    back_state_t       state_reg, state_next;
    logic [2:0]        pick_cnt_reg, pick_cnt_next;
    logic [1:0]        grp_reg, grp_next;
    logic [2:0]        elem_reg, elem_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0] counter_reg, counter_next;
    logic [WORD_W-1:0] mix1_reg, mix1_next;
    logic [WORD_W-1:0] mix2_reg, mix2_next;
    logic [WORD_W-1:0] m_reg [PICKS];
    logic [WORD_W-1:0] m_next [PICKS];

    logic [WORD_W-1:0] pool_mem [POOL_WORDS];
    logic [POOL_WORDS-1:0] vld_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] chain_word;
    logic [3:0]        pick_off;
    logic [1:0]        pick_slot;

    assign req_ready  = (state_reg == ST_IDLE);
    assign rd_word    = rd_vld_reg ? rd_data_reg : '0;
    assign chain_word = (rd_word + rotl64(m_reg[grp_reg], ROT_POOL)) ^ mix2_reg;
    assign pick_off   = 4'(pick_cnt_reg[1:0]) * 4'(PICK_STRIDE);
    assign pick_slot  = 2'(pick_cnt_reg - 3'd1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_valid && req.op == OP_ADVANCE)
                    state_next = ST_PICK;
            ST_PICK:
                if (pick_cnt_reg == 3'(PICKS))
                    state_next = ST_GROUP;
            ST_GROUP:
                state_next = ST_MADD;
            ST_MADD:
                state_next = ST_CHAIN;
            ST_CHAIN:
                if (!out_full && elem_reg == 3'(GROUP_WORDS - 1))
                    state_next = (grp_reg == 2'(GROUPS - 1)) ? ST_FOLD : ST_GROUP;
            ST_FOLD:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pick_cnt_next = pick_cnt_reg;
        grp_next      = grp_reg;
        elem_next     = elem_reg;
        idx_next      = idx_reg;
        counter_next  = counter_reg;
        mix1_next     = mix1_reg;
        mix2_next     = mix2_reg;
        for (int k = 0; k < PICKS; k++)
            m_next[k] = m_reg[k];
        rd_en     = 1'b0;
        rd_addr   = idx_reg;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = chain_word;
        out_push  = 1'b0;
        out_data.out_index = idx_reg;
        out_data.out_value = chain_word;
        out_data.out_last  = (idx_reg == IDX_W'(POOL_WORDS - 1));

        unique case (state_reg)
            ST_IDLE:
                if (req_valid)
                begin
                    unique case (req.op)
                        OP_ADVANCE:
                            pick_cnt_next = 3'd0;
                        OP_WR_POOL:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = req.widx;
                            mem_wdata = req.value;
                        end
                        OP_WR_COUNTER:
                            counter_next = req.value;
                        OP_WR_MIX1:
                            mix1_next = req.value;
                        OP_WR_MIX2:
                            mix2_next = req.value;
                        default:
                            counter_next = counter_reg;
                    endcase
                end
            ST_PICK:
            begin
                // Reads go out on counts 0 to 3; each read's data is stored on counts 1 to 4.
                if (pick_cnt_reg != 3'(PICKS))
                begin
                    rd_en   = 1'b1;
                    rd_addr = {1'b0, counter_reg[3:0] + pick_off};
                end
                if (pick_cnt_reg != 3'd0)
                    m_next[pick_slot] = rd_word;
                if (pick_cnt_reg == 3'(PICKS))
                begin
                    counter_next = counter_reg + COUNTER_STEP;
                    grp_next     = 2'd0;
                    idx_next     = '0;
                end
                pick_cnt_next = pick_cnt_reg + 3'd1;
            end
            ST_GROUP:
            begin
                mix1_next = mix1_reg + counter_reg;
                mix2_next = mix2_reg ^ counter_reg;
                rd_en     = 1'b1;
                rd_addr   = idx_reg;
            end
            ST_MADD:
            begin
                m_next[grp_reg] = m_reg[grp_reg] + rotl64(mix1_reg, ROT_GROUP);
                elem_next       = 3'd0;
            end
            ST_CHAIN:
                if (!out_full)
                begin
                    mem_we          = 1'b1;
                    out_push        = 1'b1;
                    m_next[grp_reg] = m_reg[grp_reg] + chain_word;
                    idx_next        = idx_reg + 5'd1;
                    if (elem_reg != 3'(GROUP_WORDS - 1))
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = idx_reg + 5'd1;
                        elem_next = elem_reg + 3'd1;
                    end
                    else
                    begin
                        grp_next = grp_reg + 2'd1;
                    end
                end
            ST_FOLD:
            begin
                mix1_next = (mix1_reg + rotl64(m_reg[0], ROT_FOLD1)) ^ m_reg[1];
                mix2_next = (mix2_reg + rotl64(m_reg[2], ROT_FOLD2)) ^ m_reg[3];
            end
            default:
                pick_cnt_next = pick_cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            pool_mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= pool_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < PICKS; k++)
            m_reg[k] <= m_next[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pick_cnt_reg <= 3'd0;
            grp_reg      <= 2'd0;
            elem_reg     <= 3'd0;
            idx_reg      <= '0;
            counter_reg  <= '0;
            mix1_reg     <= '0;
            mix2_reg     <= '0;
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pick_cnt_reg <= pick_cnt_next;
            grp_reg      <= grp_next;
            elem_reg     <= elem_next;
            idx_reg      <= idx_next;
            counter_reg  <= counter_next;
            mix1_reg     <= mix1_next;
            mix2_reg     <= mix2_next;
            if (mem_we)
                vld_reg[mem_waddr] <= 1'b1;
            if (rd_en)
                rd_vld_reg <= vld_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/raxp_out_fifo.sv
// Two-entry result queue between the back end and the result ports.
`default_nettype none

module raxp_out_fifo
    import raxp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire result_t wr_data,
    output logic         wr_full,
    output logic         empty,
    input  wire logic    pop,
    output result_t      result
);

    result_t    q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign wr_full = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign result  = q_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !wr_full;
    assign do_rd   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            q_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(do_wr ? 1 : 0) - 2'(do_rd ? 1 : 0);
        end
    end

endmodule

`default_nettype wire

>>> hdl/rotate_add_xor_pool_prng64.sv
// Top level of the 64-bit rotate-add-xor pool generator.
//
//  Channel   Handshake             Payload
//  -------   -------------------   ----------------------------------------
//  request   push / full           item   : func, word_index, word_value
//  result    empty / pop           result : out_index, out_value, out_last
//
// A write request is taken by the back end while idle and gives no result.
// An advance request is taken while idle, fetches the four picked words from
// the pool memory (one read a cycle), runs each of the four groups (mixer
// update, group add, then five dependent add-xor steps, one pool word a cycle
// while the result queue has room) and folds the mixes back. Its twenty
// results leave in four runs of five, with mixer update and group add between.
// Reset clears all state words at once; the pool memory carries a valid bit
// per word, so an unwritten word reads as zero and no clearing pass is needed.
// The chain pauses while the result queue is full; requests keep queuing up
// in the front end until its two entries are taken.
`default_nettype none

module rotate_add_xor_pool_prng64
    import raxp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    output logic       empty,
    input  wire logic  pop,
    output result_t    result
);

    // Decoded requests pass from the front end to the back end here.
    logic    req_valid;
    req_t    req;
    logic    req_ready;

    // Finished pool words pass from the back end into the result queue.
    logic    out_push;
    result_t out_data;
    logic    out_full;

    // The front end decodes each request and drops writes to unused indexes.
    raxp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready)
    );

    // The back end holds the generator state and runs the advance sequence.
    raxp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready),
        .out_push  (out_push),
        .out_data  (out_data),
        .out_full  (out_full)
    );

    // The result queue decouples the chain from a consumer that stalls.
    raxp_out_fifo u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_data),
        .wr_full (out_full),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

>>> sim/tb_rotate_add_xor_pool_prng64.sv
// Self-checking testbench for the 64-bit rotate-add-xor pool generator.
`default_nettype none

module tb_rotate_add_xor_pool_prng64;
    import raxp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Indexes past the mixing words, whose writes must leave the state alone, and the last pool word.
    localparam logic [IDX_W-1:0] IDX_UNUSED_LO = 5'd23;
    localparam logic [IDX_W-1:0] IDX_UNUSED_HI = 5'd31;
    localparam logic [IDX_W-1:0] IDX_LAST_POOL = 5'd19;

    localparam int RANDOM_REQUESTS = 205;
    localparam int MAX_GAP         = 10;
    // The result side stops taking words for this long once, so that both
    // queues in the block fill up and push sees full.
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AFTER      = 60;
    // Room after the last expected word for an advance in the back end plus twenty words out.
    localparam int DRAIN_CYCLES    = 80;
    localparam int CYCLE_LIMIT     = 400000;

    // The scoreboard keeps its own copy of the generator state. Every accepted
    // request is applied to that copy; an advance queues up the twenty pool
    // words the block has to deliver, in order.
    class pool_word_scoreboard;
        localparam logic [WORD_W-1:0] STEP = 64'd1111111111111;
        localparam int PICK_GAP   = 3;
        localparam int SPIN_GROUP = 19;
        localparam int SPIN_POOL  = 51;
        localparam int SPIN_FOLD1 = 47;
        localparam int SPIN_FOLD2 = 25;
        localparam int REPORT_MAX = 10;

        logic [WORD_W-1:0] pool [POOL_WORDS];
        logic [WORD_W-1:0] counter_word;
        logic [WORD_W-1:0] mixer_one;
        logic [WORD_W-1:0] mixer_two;
        result_t           expected_words [$];
        int                mismatches;

        function new();
            foreach (pool[i]) pool[i] = '0;
            counter_word = '0;
            mixer_one    = '0;
            mixer_two    = '0;
            mismatches   = 0;
        endfunction

        function logic [WORD_W-1:0] spin(input logic [WORD_W-1:0] v, input int r);
            logic [2*WORD_W-1:0] twice;
            twice = {v, v} << r;
            return twice[2*WORD_W-1:WORD_W];
        endfunction

        // One generator step on the local state.
        function void advance_pool();
            logic [WORD_W-1:0] mix [4];
            logic [3:0]        pick;
            int                w;
            w = 0;
            for (int p = 0; p < 4; p++)
            begin
                pick   = counter_word[3:0] + 4'(PICK_GAP * p);
                mix[p] = pool[pick];
            end
            counter_word += STEP;
            for (int g = 0; g < 4; g++)
            begin
                mixer_one += counter_word;
                mixer_two ^= counter_word;
                mix[g]    += spin(mixer_one, SPIN_GROUP);
                for (int e = 0; e < 5; e++)
                begin
                    pool[w] = (pool[w] + spin(mix[g], SPIN_POOL)) ^ mixer_two;
                    mix[g] += pool[w];
                    w++;
                end
            end
            mixer_one = (mixer_one + spin(mix[0], SPIN_FOLD1)) ^ mix[1];
            mixer_two = (mixer_two + spin(mix[2], SPIN_FOLD2)) ^ mix[3];
        endfunction

        function void note_request(input item_t req);
            result_t word;
            if (req.func == FUNC_WRITE)
            begin
                if (req.word_index < POOL_WORDS)
                    pool[req.word_index] = req.word_value;
                else if (req.word_index == WIDX_COUNTER)
                    counter_word = req.word_value;
                else if (req.word_index == WIDX_MIX1)
                    mixer_one = req.word_value;
                else if (req.word_index == WIDX_MIX2)
                    mixer_two = req.word_value;
                return;
            end
            advance_pool();
            for (int i = 0; i < POOL_WORDS; i++)
            begin
                word.out_index = IDX_W'(i);
                word.out_value = pool[i];
                word.out_last  = (i == POOL_WORDS - 1);
                expected_words.push_back(word);
            end
        endfunction

        function void check_word(input result_t got);
            result_t want;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected word index %0d value %h last %b",
                             $realtime, got.out_index, got.out_value, got.out_last);
                return;
            end
            want = expected_words.pop_front();
            if (got.out_index !== want.out_index || got.out_value !== want.out_value ||
                got.out_last !== want.out_last)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: expected index %0d value %h last %b, got %0d %h %b",
                             $realtime, want.out_index, want.out_value, want.out_last,
                             got.out_index, got.out_value, got.out_last);
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic    clk;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    logic    pop   = 1'b0;
    item_t   item  = '0;
    logic    full;
    logic    empty;
    result_t result;

    pool_word_scoreboard sb = new();
    int cycles = 0;

    rotate_add_xor_pool_prng64 dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Both handshakes are sampled here, in the same time step as the edge and
    // before any register in the block has taken its new value.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_request(item);
            if (pop && !empty)
                sb.check_word(result);
        end
    end

    // Watchdog: the whole run must finish well inside this many cycles.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic item_t make_item(input logic f, input logic [IDX_W-1:0] idx,
                                        input logic [WORD_W-1:0] v);
        item_t req;
        req.func       = f;
        req.word_index = idx;
        req.word_value = v;
        return req;
    endfunction

    // Mostly full-width random words, with the two extremes now and then.
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Offers one request after an optional idle gap and returns at the edge
    // where it was taken. Push is touched at most once per time step, so a
    // back-to-back request simply keeps push high.
    task automatic offer_request(input item_t req, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Result side: a random gap before each word, a run of words taken with no
    // gaps every so often, and one long hold-off early in the run.
    task automatic drain_results();
        int  taken;
        int  gap;
        bit  held;
        taken = 0;
        held  = 1'b0;
        forever
        begin
            if (!held && taken >= HOLD_AFTER)
            begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            else if ((taken / 100) % 3 == 2)
                gap = 0;
            else
                gap = $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            taken++;
        end
    endtask

    initial
    begin
        item_t req;
        int    counted;
        int    n;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        fork
            drain_results();
        join_none

        // Directed part. First an advance from the all-zero reset state.
        offer_request(make_item(FUNC_ADVANCE, '0, '0), 1'b0);
        // All-ones words at both ends of the pool and in the counter, so the
        // counter add wraps and the pick window wraps from word 15 to 2, 5, 8.
        offer_request(make_item(FUNC_WRITE, '0, '1), 1'b0);
        offer_request(make_item(FUNC_WRITE, IDX_LAST_POOL, '1), 1'b0);
        offer_request(make_item(FUNC_WRITE, WIDX_COUNTER, '1), 1'b0);
        offer_request(make_item(FUNC_WRITE, WIDX_MIX1, '1), 1'b0);
        offer_request(make_item(FUNC_WRITE, WIDX_MIX2, 64'h8000_0000_0000_0001), 1'b0);
        // The index and value of an advance are don't-cares.
        offer_request(make_item(FUNC_ADVANCE, IDX_UNUSED_HI, '1), 1'b0);
        // Writes past the mixing words must change nothing.
        offer_request(make_item(FUNC_WRITE, IDX_UNUSED_LO, random_word()), 1'b0);
        offer_request(make_item(FUNC_WRITE, IDX_UNUSED_HI, '1), 1'b0);
        offer_request(make_item(FUNC_ADVANCE, WIDX_MIX2, random_word()), 1'b0);
        // Pick windows that wrap past word 15: bases 13 and 7.
        offer_request(make_item(FUNC_WRITE, WIDX_COUNTER, 64'hD), 1'b0);
        offer_request(make_item(FUNC_ADVANCE, '0, '0), 1'b0);
        offer_request(make_item(FUNC_WRITE, WIDX_COUNTER, 64'h7), 1'b0);
        offer_request(make_item(FUNC_WRITE, 5'd15, random_word()), 1'b0);
        offer_request(make_item(FUNC_WRITE, 5'd10, random_word()), 1'b0);
        offer_request(make_item(FUNC_ADVANCE, '0, '0), 1'b0);
        // Cleared mixers and a counter just below the wrap point.
        offer_request(make_item(FUNC_WRITE, WIDX_MIX1, '0), 1'b0);
        offer_request(make_item(FUNC_WRITE, WIDX_MIX2, '0), 1'b0);
        offer_request(make_item(FUNC_WRITE, WIDX_COUNTER, 64'hFFFF_FFFF_FFFF_FFF0), 1'b0);
        offer_request(make_item(FUNC_ADVANCE, '0, '0), 1'b1);
        offer_request(make_item(FUNC_ADVANCE, IDX_LAST_POOL, '1), 1'b1);
        offer_request(make_item(FUNC_WRITE, 5'd7, '0), 1'b0);
        offer_request(make_item(FUNC_ADVANCE, '0, '0), 1'b0);

        // Random part. Ignored writes do not count toward the total. Every
        // third stretch of forty requests is sent with no gaps at all.
        counted = 0;
        n       = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            if ($urandom_range(0, 99) < 35)
                req = make_item(FUNC_ADVANCE, IDX_W'($urandom_range(0, 31)), random_word());
            else if ($urandom_range(0, 99) < 85)
                req = make_item(FUNC_WRITE, IDX_W'($urandom_range(0, 22)), random_word());
            else
                req = make_item(FUNC_WRITE, IDX_W'($urandom_range(0, 31)), random_word());
            offer_request(req, ((n / 40) % 3) == 1);
            if (!(req.func == FUNC_WRITE && req.word_index > WIDX_MIX2))
                counted++;
            n++;
        end
        push <= 1'b0;

        // Let the last request reach the scoreboard, wait for its words, then
        // leave room for any word the block should not have produced.
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hdl/raxp_pkg.sv
hdl/raxp_front.sv
hdl/raxp_back.sv
hdl/raxp_out_fifo.sv
hdl/rotate_add_xor_pool_prng64.sv
sim/tb_rotate_add_xor_pool_prng64.sv
